[design/esth_pkg.sv]
// Shared types, register codes, reset values and the quadrature decode table
// for the encoder setpoint thermostat. No dependencies.
`default_nettype none

package esth_pkg;

  typedef enum logic [1:0] {
    REG_CONTROL_PERIOD  = 2'd0,
    REG_DEBOUNCE_TICKS  = 2'd1,
    REG_SETPOINT_MAX    = 2'd2,
    REG_ENCODER_REVERSE = 2'd3
  } reg_index_t;

  localparam logic [15:0] CONTROL_PERIOD_RST = 16'd83;
  localparam logic [7:0]  DEBOUNCE_TICKS_RST = 8'd30;
  localparam logic [9:0]  SETPOINT_MAX_RST   = 10'd1023;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESS   = 2'd1,
    PH_RELEASE = 2'd2
  } button_phase_t;

  typedef struct packed {
    logic [15:0] control_period;
    logic [7:0]  debounce_ticks;
    logic [9:0]  setpoint_max;
    logic        encoder_reverse;
  } esth_cfg_t;

  // Quadrature step for {previous A/B, current A/B}.
  function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
    logic signed [1:0] d;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = 2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = -2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[design/esth_if.sv]
// Valid/ready channel interfaces for the thermostat tick items and results.
// Depends on nothing.
`default_nettype none

interface esth_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  encoder_ab;
  logic        button_pressed;
  logic        sensor_valid;
  logic [15:0] sensor_word;
  modport source (output valid, encoder_ab, button_pressed, sensor_valid, sensor_word,
                  input ready);
  modport sink   (input valid, encoder_ab, button_pressed, sensor_valid, sensor_word,
                  output ready);
endinterface

interface esth_out_if;
  logic       valid;
  logic       ready;
  logic       ssr_on;
  logic [9:0] shown_setpoint;
  logic [9:0] goal_setpoint;
  logic       goal_pending;
  logic [9:0] current_temp;
  modport source (output valid, ssr_on, shown_setpoint, goal_setpoint, goal_pending,
                  current_temp, input ready);
  modport sink   (input valid, ssr_on, shown_setpoint, goal_setpoint, goal_pending,
                  current_temp, output ready);
endinterface

`default_nettype wire

[design/esth_cfg.sv]
// APB-style configuration registers of the thermostat.
// Depends on esth_pkg.
`default_nettype none

module esth_cfg
  import esth_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output esth_cfg_t        cfg
);

  esth_cfg_t  cfg_r;
  reg_index_t idx;
  logic       wr;

  assign idx        = reg_index_t'(cfg_paddr[3:2]);
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.control_period  <= CONTROL_PERIOD_RST;
      cfg_r.debounce_ticks  <= DEBOUNCE_TICKS_RST;
      cfg_r.setpoint_max    <= SETPOINT_MAX_RST;
      cfg_r.encoder_reverse <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_CONTROL_PERIOD:  cfg_r.control_period  <= cfg_pwdata[15:0];
        REG_DEBOUNCE_TICKS:  cfg_r.debounce_ticks  <= cfg_pwdata[7:0];
        REG_SETPOINT_MAX:    cfg_r.setpoint_max    <= cfg_pwdata[9:0];
        REG_ENCODER_REVERSE: cfg_r.encoder_reverse <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CONTROL_PERIOD:  cfg_prdata = {16'd0, cfg_r.control_period};
      REG_DEBOUNCE_TICKS:  cfg_prdata = {24'd0, cfg_r.debounce_ticks};
      REG_SETPOINT_MAX:    cfg_prdata = {22'd0, cfg_r.setpoint_max};
      REG_ENCODER_REVERSE: cfg_prdata = {31'd0, cfg_r.encoder_reverse};
      default:             cfg_prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[design/esth_encoder.sv]
// Quadrature decoder and shown-setpoint counter.
// Depends on esth_pkg.
`default_nettype none

module esth_encoder
  import esth_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       tick,
  input  wire logic [1:0] ab,
  input  wire esth_cfg_t  cfg,
  output logic [9:0]      shown_nxt,
  output logic [9:0]      shown_r
);

  logic [1:0]        prev_r;
  logic signed [3:0] step_r, step_nxt, sum;
  logic signed [3:0] d;
  logic [10:0]       moved;
  logic              up, down;

  always_comb begin
    d    = 4'(quad_delta({prev_r, ab}));
    sum  = cfg.encoder_reverse ? step_r + d : step_r - d;
    up   = (sum == 4'sd4);
    down = (sum == -4'sd4);
    step_nxt = (up || down) ? 4'sd0 : sum;
    if (up) begin
      moved = {1'b0, shown_r} + 11'd1;
    end else if (shown_r != 10'd0) begin
      moved = {1'b0, shown_r} - 11'd1;
    end else begin
      moved = 11'd0;
    end
    if (moved > {1'b0, cfg.setpoint_max}) begin
      moved = {1'b0, cfg.setpoint_max};
    end
    shown_nxt = (up || down) ? moved[9:0] : shown_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 2'd0;
      step_r  <= 4'sd0;
      shown_r <= 10'd0;
    end else if (tick) begin
      prev_r  <= ab;
      step_r  <= step_nxt;
      shown_r <= shown_nxt;
    end
  end

endmodule

`default_nettype wire

[design/esth_button.sv]
// Debounced button state machine that commits the shown setpoint as goal.
// Depends on esth_pkg.
`default_nettype none

module esth_button
  import esth_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       tick,
  input  wire logic       pressed,
  input  wire logic [9:0] shown_nxt,
  input  wire esth_cfg_t  cfg,
  output logic [9:0]      goal_nxt,
  output logic [9:0]      goal_r
);

  button_phase_t phase_r, phase_nxt;
  logic [7:0]    wait_r, wait_nxt;

  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    goal_nxt  = goal_r;
    if (wait_r != 8'd0) begin
      wait_nxt = wait_r - 8'd1;
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (pressed) begin
            phase_nxt = PH_PRESS;
            wait_nxt  = (cfg.debounce_ticks == 8'd0) ? 8'd0 : cfg.debounce_ticks - 8'd1;
          end
        end
        PH_PRESS: begin
          if (pressed) begin
            goal_nxt  = shown_nxt;
            phase_nxt = PH_RELEASE;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          if (!pressed) phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wait_r  <= 8'd0;
      goal_r  <= 10'd0;
    end else if (tick) begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      goal_r  <= goal_nxt;
    end
  end

endmodule

`default_nettype wire

[design/esth_control.sv]
// Slotted relay drive: control period timer, power word and slot pointer.
// Depends on esth_pkg.
`default_nettype none

module esth_control
  import esth_pkg::*;
#(
  parameter int POWER_SLOTS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       tick,
  input  wire logic [9:0] goal_nxt,
  input  wire logic [9:0] temp_r,
  input  wire esth_cfg_t  cfg,
  output logic            ssr_r
);

  localparam int SLOT_W = $clog2(POWER_SLOTS);

  logic [15:0]            wait_r;
  logic [POWER_SLOTS-1:0] power_r;
  logic [SLOT_W-1:0]      slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r  <= 16'd0;
      power_r <= '0;
      slot_r  <= '0;
      ssr_r   <= 1'b0;
    end else if (tick) begin
      if (wait_r != 16'd0) begin
        wait_r <= wait_r - 16'd1;
      end else begin
        wait_r  <= (cfg.control_period == 16'd0) ? 16'd0 : cfg.control_period - 16'd1;
        ssr_r   <= power_r[slot_r];
        slot_r  <= (slot_r == SLOT_W'(POWER_SLOTS - 1)) ? '0 : slot_r + SLOT_W'(1);
        power_r <= (goal_nxt > temp_r) ? '1 : '0;
      end
    end
  end

endmodule

`default_nettype wire

[design/encoder_setpoint_thermostat_core.sv]
// Top level of the encoder setpoint thermostat.
// Depends on esth_pkg, esth_if and the esth_cfg/encoder/button/control modules.
`default_nettype none
// Usage:
//   in_if  : one item per 1 ms tick (encoder A/B, button level, sensor word).
//   out_if : one result item per input item (relay level, shown and goal
//            setpoints, pending flag, temperature).
//   cfg_*  : APB-style register port, registers at byte addresses 0,4,8,12;
//            pready is tied high, reads return the register value.
// Latency: a result is valid the cycle after its item is accepted.
// Throughput: one item per clock while out_if.ready keeps up. All tick state updates
//   through short logic; the state registers themselves hold the result payload.
// Stall: while a result waits, in_if.ready drops unless out_if.ready is high
//   in the same cycle, so a new item is taken as the old result leaves and
//   the held payload never changes under a stall.
// Reset (rst_n low, synchronous): registers return to their defaults
//   (period 83, debounce 30, max 1023, normal direction), all tick state
//   clears, and no result is valid.  The relay control fires on the first
//   tick after reset.

module encoder_setpoint_thermostat_core
  import esth_pkg::*;
#(
  parameter int POWER_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  esth_in_if.sink          in_if,
  esth_out_if.source       out_if,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  esth_cfg_t  cfg;
  logic       tick;
  logic       out_valid_r;
  logic [9:0] shown_nxt, shown_r;
  logic [9:0] goal_nxt, goal_r;
  logic [9:0] temp_r;
  logic       ssr_r;

  // Take an item whenever the result slot is empty or being drained.
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign tick        = in_if.valid && in_if.ready;

  esth_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg
  );

  esth_encoder u_encoder (
    .clk, .rst_n, .tick, .ab(in_if.encoder_ab), .cfg, .shown_nxt, .shown_r
  );

  // Goal sees this tick's shown value (encoder runs first).
  esth_button u_button (
    .clk, .rst_n, .tick, .pressed(in_if.button_pressed), .shown_nxt, .cfg,
    .goal_nxt, .goal_r
  );

  // Control compares this tick's goal with the temperature from before the
  // sensor update of the same tick.
  esth_control #(.POWER_SLOTS(POWER_SLOTS)) u_control (
    .clk, .rst_n, .tick, .goal_nxt, .temp_r, .cfg, .ssr_r
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r      <= 10'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (tick && in_if.sensor_valid) temp_r <= in_if.sensor_word[15:6];
      if (tick) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.ssr_on         = ssr_r;
  assign out_if.shown_setpoint = shown_r;
  assign out_if.goal_setpoint  = goal_r;
  assign out_if.goal_pending   = (shown_r != goal_r);
  assign out_if.current_temp   = temp_r;

`ifndef SYNTH
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> out_if.valid)
    else $error("accepted item produced no result");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ready) |=>
      ($stable(shown_r) && $stable(goal_r) && $stable(ssr_r) && $stable(temp_r)))
    else $error("tick state advanced while result was stalled");

  a_temp_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !tick |=> $stable(temp_r))
    else $error("temperature changed without an accepted item");
`endif

endmodule

`default_nettype wire
